// File: sv/srfl_pkg.sv
`timescale 1ns / 1ps

package srfl_pkg;

   // Store geometry.
   localparam int DEPTH  = 1024;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Fixed widths of the result fields.
   localparam int VALUE_W = 32;
   localparam int IDX_W   = 10;
   localparam int OCC_W   = 11;

   // Operation codes carried by a request word.
   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST_PROBE,
      ST_FIRST_CMP,
      ST_LAST_PROBE,
      ST_LAST_CMP
   } state_type;

   typedef struct packed {
      logic [1:0]                operation;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] first_index;
      logic [IDX_W-1:0] last_index;
      logic [OCC_W-1:0] occurrences;
   } rsp_type;

endpackage

// File: sv/srfl_ram.sv
`timescale 1ns / 1ps

module srfl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/sorted_range_first_last_search.sv
// Clear and append words are taken only while idle and leave busy low.
// A query word keeps busy high through a leftward and then a rightward search, each of
// at most 11 probes. Each probe is a memory read state followed by a compare state.
// The result strobe is high in the first cycle with busy low; a new query is not taken
// until the previous one has finished, so queries cannot overlap.
// The receiver cannot stall. Synchronous reset empties the store and idles the sequencer.
`timescale 1ns / 1ps

module sorted_range_first_last_search (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  srfl_pkg::req_type req_data,
   output logic             rsp_valid,
   output srfl_pkg::rsp_type rsp_data
);

   import srfl_pkg::*;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]          lo_ff, lo_in;
   logic [CNT_W-1:0]          hi1_ff, hi1_in;   // upper bound plus one
   logic [ADDR_W-1:0]         mid_ff, mid_in;
   logic [ADDR_W-1:0]         first_ff, first_in;
   logic                      first_hit_ff, first_hit_in;
   logic [ADDR_W-1:0]         last_ff, last_in;
   logic                      last_hit_ff, last_hit_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      accept;
   logic                      range_open;
   logic [CNT_W:0]            mid_sum;
   logic [ADDR_W-1:0]         mid;
   logic [CNT_W-1:0]          mid_plus1;
   logic signed [VALUE_W-1:0] rd_data;
   logic                      wr_en;
   logic                      rd_en;

   assign accept = start && (state_ff == ST_IDLE);

   // Midpoint of the open range [lo, hi1).
   assign range_open = lo_ff < hi1_ff;
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi1_ff} - {{CNT_W{1'b0}}, 1'b1};
   assign mid        = mid_sum[ADDR_W:1];
   assign mid_plus1  = CNT_W'(mid_ff) + {{(CNT_W-1){1'b0}}, 1'b1};

   // Appends write straight into the store while the block is idle.
   assign wr_en = accept && (req_data.operation == OP_APPEND) && (count_ff < CNT_W'(DEPTH));
   assign rd_en = ((state_ff == ST_FIRST_PROBE) || (state_ff == ST_LAST_PROBE)) && range_open;

   srfl_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_data.value),
      .rd_en   (rd_en),
      .rd_addr (mid),
      .rd_data (rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.operation == OP_QUERY)) begin
               state_in = ST_FIRST_PROBE;
            end
         end
         ST_FIRST_PROBE: begin
            state_in = range_open ? ST_FIRST_CMP : ST_LAST_PROBE;
         end
         ST_FIRST_CMP: begin
            state_in = ST_FIRST_PROBE;
         end
         ST_LAST_PROBE: begin
            state_in = range_open ? ST_LAST_CMP : ST_IDLE;
         end
         ST_LAST_CMP: begin
            state_in = ST_LAST_PROBE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath updates for each state.
   always_comb begin
      count_in     = count_ff;
      key_in       = key_ff;
      lo_in        = lo_ff;
      hi1_in       = hi1_ff;
      mid_in       = mid_ff;
      first_in     = first_ff;
      first_hit_in = first_hit_ff;
      last_in      = last_ff;
      last_hit_in  = last_hit_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.operation)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_APPEND: begin
                     if (count_ff < CNT_W'(DEPTH)) begin
                        count_in = count_ff + {{(CNT_W-1){1'b0}}, 1'b1};
                     end
                  end
                  OP_QUERY: begin
                     key_in       = req_data.value;
                     lo_in        = '0;
                     hi1_in       = count_ff;
                     first_hit_in = 1'b0;
                     last_hit_in  = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FIRST_PROBE: begin
            mid_in = mid;
            if (!range_open) begin
               lo_in  = '0;
               hi1_in = count_ff;
            end
         end
         ST_FIRST_CMP: begin
            // Leftward search: on a match keep going to the left.
            if (rd_data >= key_ff) begin
               if (rd_data == key_ff) begin
                  first_in     = mid_ff;
                  first_hit_in = 1'b1;
               end
               hi1_in = CNT_W'(mid_ff);
            end else begin
               lo_in = mid_plus1;
            end
         end
         ST_LAST_PROBE: begin
            mid_in = mid;
            if (!range_open) begin
               rsp_valid_in = 1'b1;
               if (first_hit_ff && last_hit_ff) begin
                  rsp_in.found       = 1'b1;
                  rsp_in.first_index = IDX_W'(first_ff);
                  rsp_in.last_index  = IDX_W'(last_ff);
                  if (last_ff >= first_ff) begin
                     rsp_in.occurrences = OCC_W'(CNT_W'(last_ff - first_ff) +
                                                 {{(CNT_W-1){1'b0}}, 1'b1});
                  end else begin
                     rsp_in.occurrences = '0;
                  end
               end else begin
                  rsp_in = '0;
               end
            end
         end
         ST_LAST_CMP: begin
            // Rightward search: on a match keep going to the right.
            if (rd_data <= key_ff) begin
               if (rd_data == key_ff) begin
                  last_in     = mid_ff;
                  last_hit_in = 1'b1;
               end
               lo_in = mid_plus1;
            end else begin
               hi1_in = CNT_W'(mid_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Search and result registers.
   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      lo_ff        <= lo_in;
      hi1_ff       <= hi1_in;
      mid_ff       <= mid_in;
      first_ff     <= first_in;
      first_hit_ff <= first_hit_in;
      last_ff      <= last_in;
      last_hit_ff  <= last_hit_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: sv/srfl_checker.sv
`timescale 1ns / 1ps

module srfl_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input srfl_pkg::req_type req_data,
   input logic              rsp_valid,
   input srfl_pkg::rsp_type rsp_data
);

   import srfl_pkg::*;

   // A query word makes the block busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.operation == OP_QUERY)) |=> busy)
      else $error("query word did not start a search");

   // A result word is a single-cycle strobe.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // The result comes out once the search has finished.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result word while search still running");

   // A missing key reports all-zero indices and count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |->
         ((rsp_data.first_index == '0) && (rsp_data.last_index == '0) &&
          (rsp_data.occurrences == '0)))
      else $error("nonzero fields in a not-found result word");

endmodule

bind sorted_range_first_last_search srfl_checker u_srfl_checker (.*);
